// ===== rtl/dmce_pkg.sv =====
// Shared types, constants and codes for the draw macro command executor.
package dmce_pkg;

  // Internal coordinate width; all pen arithmetic wraps at this width.
  localparam int COORD_W = 32;
  // Width of every coordinate field on the result channel.
  localparam int OUT_W = 32;
  localparam int CANVAS_W = 16;
  localparam int PARAM_W = 16;
  localparam int SCALE_W = 8;
  localparam int COLOR_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CANVAS_W-1:0] CANVAS_W_RST = CANVAS_W'(320);
  localparam logic [CANVAS_W-1:0] CANVAS_H_RST = CANVAS_W'(200);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(4);
  localparam logic [COLOR_W-1:0] COLOR_RST = COLOR_W'(1);
  localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OUT_W-1:0] out_coord_t;

  // Command codes.
  typedef enum logic [3:0] {
    CMD_U   = 4'd0,
    CMD_D   = 4'd1,
    CMD_L   = 4'd2,
    CMD_R   = 4'd3,
    CMD_E   = 4'd4,
    CMD_F   = 4'd5,
    CMD_G   = 4'd6,
    CMD_H   = 4'd7,
    CMD_B   = 4'd8,
    CMD_N   = 4'd9,
    CMD_C   = 4'd10,
    CMD_S   = 4'd11,
    CMD_M   = 4'd12,
    CMD_A   = 4'd13,
    CMD_T   = 4'd14,
    CMD_UNK = 4'd15
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_LINE    = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CANVAS_WIDTH  = 2'd0,
    CFG_CANVAS_HEIGHT = 2'd1
  } cfg_idx_e;

  // One parsed command.
  typedef struct packed {
    cmd_e                       cmd;
    logic signed [PARAM_W-1:0]  param_a;
    logic signed [PARAM_W-1:0]  param_b;
  } item_t;

  // Pen state carried from command to command.
  typedef struct packed {
    coord_t               pos_x;
    coord_t               pos_y;
    coord_t               min_x;
    coord_t               min_y;
    coord_t               max_x;
    coord_t               max_y;
    logic [SCALE_W-1:0]   step_scale;
    logic [COLOR_W-1:0]   color_index;
    logic                 pen_lifted;
    logic                 return_home;
  } pen_state_t;

  // One result beat.
  typedef struct packed {
    status_e              status;
    out_coord_t           seg_start_x;
    out_coord_t           seg_start_y;
    out_coord_t           seg_end_x;
    out_coord_t           seg_end_y;
    logic [COLOR_W-1:0]   line_color;
    out_coord_t           box_min_x;
    out_coord_t           box_min_y;
    out_coord_t           box_max_x;
    out_coord_t           box_max_y;
    out_coord_t           pen_x;
    out_coord_t           pen_y;
  } result_t;

  // Home coordinate for a canvas dimension: half of it, zero extended.
  function automatic coord_t home_coord(input logic [CANVAS_W-1:0] dim);
    logic [CANVAS_W-1:0] half;
    half = dim >> 1;
    return coord_t'(half);
  endfunction

  // Sign-extend or truncate an internal coordinate to the output width.
  function automatic out_coord_t to_out(input coord_t c);
    return OUT_W'(c);
  endfunction

endpackage

// ===== rtl/dmce_if.sv =====
// Valid/ready channel interfaces for commands, results and configuration.
interface dmce_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [3:0]                             cmd;
  logic signed [dmce_pkg::PARAM_W-1:0]    param_a;
  logic signed [dmce_pkg::PARAM_W-1:0]    param_b;

  modport source (output valid, cmd, param_a, param_b, input ready);
  modport sink (input valid, cmd, param_a, param_b, output ready);
endinterface

interface dmce_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             status;
  logic signed [dmce_pkg::OUT_W-1:0]      seg_start_x;
  logic signed [dmce_pkg::OUT_W-1:0]      seg_start_y;
  logic signed [dmce_pkg::OUT_W-1:0]      seg_end_x;
  logic signed [dmce_pkg::OUT_W-1:0]      seg_end_y;
  logic [dmce_pkg::COLOR_W-1:0]           line_color;
  logic signed [dmce_pkg::OUT_W-1:0]      box_min_x;
  logic signed [dmce_pkg::OUT_W-1:0]      box_min_y;
  logic signed [dmce_pkg::OUT_W-1:0]      box_max_x;
  logic signed [dmce_pkg::OUT_W-1:0]      box_max_y;
  logic signed [dmce_pkg::OUT_W-1:0]      pen_x;
  logic signed [dmce_pkg::OUT_W-1:0]      pen_y;

  modport source (output valid, status, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  line_color, box_min_x, box_min_y, box_max_x, box_max_y, pen_x, pen_y,
                  input ready);
  modport sink (input valid, status, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                line_color, box_min_x, box_min_y, box_max_x, box_max_y, pen_x, pen_y,
                output ready);
endinterface

interface dmce_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [dmce_pkg::CFG_IDX_W-1:0]         index;
  logic [dmce_pkg::CANVAS_W-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/dmce_step.sv =====
// Combinational step: applies one command to the pen state and forms its result.
module dmce_step (
  input  dmce_pkg::item_t       item,
  input  dmce_pkg::pen_state_t  cur,
  output dmce_pkg::pen_state_t  nxt,
  output dmce_pkg::result_t     res
);

  logic signed [dmce_pkg::SCALE_W:0]                    scale_s;
  logic signed [dmce_pkg::SCALE_W+dmce_pkg::PARAM_W:0]  prod_a;
  logic signed [dmce_pkg::SCALE_W+dmce_pkg::PARAM_W:0]  prod_b;
  dmce_pkg::coord_t   move_len;
  dmce_pkg::coord_t   abs_y;
  dmce_pkg::coord_t   tx;
  dmce_pkg::coord_t   ty;
  logic               is_move;
  dmce_pkg::coord_t   lo_x, lo_y, hi_x, hi_y;
  dmce_pkg::coord_t   seg_sx, seg_sy, seg_ex, seg_ey;
  logic [dmce_pkg::SCALE_W-1:0] new_scale;
  dmce_pkg::status_e  step_status;

  // Scaled distance and scaled absolute y; the scale is always non-negative.
  assign scale_s  = $signed({1'b0, cur.step_scale});
  assign prod_a   = scale_s * item.param_a;
  assign prod_b   = scale_s * item.param_b;
  assign move_len = dmce_pkg::COORD_W'(prod_a);
  assign abs_y    = dmce_pkg::COORD_W'(prod_b);

  // Target point for the eight direction moves and the absolute move.
  always_comb begin
    tx      = cur.pos_x;
    ty      = cur.pos_y;
    is_move = 1'b1;
    case (item.cmd)
      dmce_pkg::CMD_U: ty = cur.pos_y - move_len;
      dmce_pkg::CMD_D: ty = cur.pos_y + move_len;
      dmce_pkg::CMD_L: tx = cur.pos_x - move_len;
      dmce_pkg::CMD_R: tx = cur.pos_x + move_len;
      dmce_pkg::CMD_E: begin
        tx = cur.pos_x + move_len;
        ty = cur.pos_y - move_len;
      end
      dmce_pkg::CMD_F: begin
        tx = cur.pos_x + move_len;
        ty = cur.pos_y + move_len;
      end
      dmce_pkg::CMD_G: begin
        tx = cur.pos_x - move_len;
        ty = cur.pos_y + move_len;
      end
      dmce_pkg::CMD_H: begin
        tx = cur.pos_x - move_len;
        ty = cur.pos_y - move_len;
      end
      dmce_pkg::CMD_M: begin
        tx = move_len;
        ty = abs_y;
      end
      default: is_move = 1'b0;
    endcase
  end

  // Segment extremes, signed compares at the coordinate width.
  assign lo_x = (tx < cur.pos_x) ? tx : cur.pos_x;
  assign hi_x = (tx > cur.pos_x) ? tx : cur.pos_x;
  assign lo_y = (ty < cur.pos_y) ? ty : cur.pos_y;
  assign hi_y = (ty > cur.pos_y) ? ty : cur.pos_y;

  // Scale is the argument divided by four toward zero, clamped to 0..255.
  always_comb begin
    if (item.param_a < 0) begin
      new_scale = '0;
    end else if (|item.param_a[dmce_pkg::PARAM_W-2:dmce_pkg::SCALE_W+2]) begin
      new_scale = dmce_pkg::SCALE_MAX;
    end else begin
      new_scale = item.param_a[dmce_pkg::SCALE_W+1:2];
    end
  end

  // Next state and status.
  always_comb begin
    nxt         = cur;
    step_status = dmce_pkg::ST_NONE;
    seg_sx      = '0;
    seg_sy      = '0;
    seg_ex      = '0;
    seg_ey      = '0;
    if (is_move) begin
      if (!cur.pen_lifted) begin
        step_status = dmce_pkg::ST_LINE;
        seg_sx      = cur.pos_x;
        seg_sy      = cur.pos_y;
        seg_ex      = tx;
        seg_ey      = ty;
        nxt.min_x   = (lo_x < cur.min_x) ? lo_x : cur.min_x;
        nxt.min_y   = (lo_y < cur.min_y) ? lo_y : cur.min_y;
        nxt.max_x   = (hi_x > cur.max_x) ? hi_x : cur.max_x;
        nxt.max_y   = (hi_y > cur.max_y) ? hi_y : cur.max_y;
      end else begin
        nxt.pen_lifted = 1'b0;
      end
      if (!cur.return_home) begin
        nxt.pos_x = tx;
        nxt.pos_y = ty;
      end else begin
        nxt.return_home = 1'b0;
      end
    end else begin
      case (item.cmd)
        dmce_pkg::CMD_B: nxt.pen_lifted = 1'b1;
        dmce_pkg::CMD_N: nxt.return_home = 1'b1;
        dmce_pkg::CMD_C: nxt.color_index = item.param_a[dmce_pkg::COLOR_W-1:0];
        dmce_pkg::CMD_S: nxt.step_scale = new_scale;
        dmce_pkg::CMD_A, dmce_pkg::CMD_T: ;
        default: step_status = dmce_pkg::ST_UNKNOWN;
      endcase
    end
  end

  // Result fields reflect the state after the command.
  assign res.status      = step_status;
  assign res.seg_start_x = dmce_pkg::to_out(seg_sx);
  assign res.seg_start_y = dmce_pkg::to_out(seg_sy);
  assign res.seg_end_x   = dmce_pkg::to_out(seg_ex);
  assign res.seg_end_y   = dmce_pkg::to_out(seg_ey);
  assign res.line_color  = nxt.color_index;
  assign res.box_min_x   = dmce_pkg::to_out(nxt.min_x);
  assign res.box_min_y   = dmce_pkg::to_out(nxt.min_y);
  assign res.box_max_x   = dmce_pkg::to_out(nxt.max_x);
  assign res.box_max_y   = dmce_pkg::to_out(nxt.max_y);
  assign res.pen_x       = dmce_pkg::to_out(nxt.pos_x);
  assign res.pen_y       = dmce_pkg::to_out(nxt.pos_y);

endmodule

// ===== rtl/draw_macro_command_executor.sv =====
// Top level of the draw macro command executor: input register, pen state, result register.
//
//   Channel  Dir  Payload                                      Beat taken when
//   in_ch    in   cmd, param_a, param_b                        valid && ready
//   out_ch   out  status, segment, line_color, box, pen        valid && ready
//   cfg_ch   in   index, data (canvas width or height)         valid && ready
//
// One command per cycle sustained while the result side is ready.
// The command sits in an input register, and the pen state is updated as it moves on
// to the result register, so the next command in the input register already sees the new state.
// A stalled result holds; the input register still fills, so one more beat is taken.
// Reset (rst_n low, synchronous) homes the pen to the center of a 320 by 200 canvas.
// Configuration writes are always accepted.
module draw_macro_command_executor (
  input  logic        clk,
  input  logic        rst_n,
  dmce_in_if.sink     in_ch,
  dmce_out_if.source  out_ch,
  dmce_cfg_if.sink    cfg_ch
);

  dmce_pkg::item_t       item_r;
  logic                  item_valid_r;
  dmce_pkg::pen_state_t  state_r;
  dmce_pkg::pen_state_t  state_nxt;
  dmce_pkg::pen_state_t  step_nxt;
  dmce_pkg::result_t     res_r;
  dmce_pkg::result_t     step_res;
  logic                  out_valid_r;
  logic                  advance;
  logic                  in_beat;
  logic                  cfg_beat;

  // Handshake control.
  assign advance      = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !item_valid_r || advance;
  assign in_beat      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_beat     = cfg_ch.valid;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_beat) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      item_r.cmd     <= dmce_pkg::cmd_e'(in_ch.cmd);
      item_r.param_a <= in_ch.param_a;
      item_r.param_b <= in_ch.param_b;
    end
  end

  // Command execution.
  dmce_step u_step (
    .item (item_r),
    .cur  (state_r),
    .nxt  (step_nxt),
    .res  (step_res)
  );

  // Pen state next value: a canvas write re-homes one axis and wins over a command step in the same cycle.
  always_comb begin
    state_nxt = state_r;
    if (cfg_beat) begin
      case (cfg_ch.index)
        dmce_pkg::CFG_CANVAS_WIDTH: begin
          state_nxt.pos_x = dmce_pkg::home_coord(cfg_ch.data);
          state_nxt.min_x = dmce_pkg::home_coord(cfg_ch.data);
          state_nxt.max_x = dmce_pkg::home_coord(cfg_ch.data);
        end
        dmce_pkg::CFG_CANVAS_HEIGHT: begin
          state_nxt.pos_y = dmce_pkg::home_coord(cfg_ch.data);
          state_nxt.min_y = dmce_pkg::home_coord(cfg_ch.data);
          state_nxt.max_y = dmce_pkg::home_coord(cfg_ch.data);
        end
        default: ;
      endcase
    end else if (advance) begin
      state_nxt = step_nxt;
    end
  end

  // Pen state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.pos_x       <= dmce_pkg::home_coord(dmce_pkg::CANVAS_W_RST);
      state_r.min_x       <= dmce_pkg::home_coord(dmce_pkg::CANVAS_W_RST);
      state_r.max_x       <= dmce_pkg::home_coord(dmce_pkg::CANVAS_W_RST);
      state_r.pos_y       <= dmce_pkg::home_coord(dmce_pkg::CANVAS_H_RST);
      state_r.min_y       <= dmce_pkg::home_coord(dmce_pkg::CANVAS_H_RST);
      state_r.max_y       <= dmce_pkg::home_coord(dmce_pkg::CANVAS_H_RST);
      state_r.step_scale  <= dmce_pkg::SCALE_RST;
      state_r.color_index <= dmce_pkg::COLOR_RST;
      state_r.pen_lifted  <= 1'b0;
      state_r.return_home <= 1'b0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  // Result channel drive.
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = res_r.status;
  assign out_ch.seg_start_x = res_r.seg_start_x;
  assign out_ch.seg_start_y = res_r.seg_start_y;
  assign out_ch.seg_end_x   = res_r.seg_end_x;
  assign out_ch.seg_end_y   = res_r.seg_end_y;
  assign out_ch.line_color  = res_r.line_color;
  assign out_ch.box_min_x   = res_r.box_min_x;
  assign out_ch.box_min_y   = res_r.box_min_y;
  assign out_ch.box_max_x   = res_r.box_max_x;
  assign out_ch.box_max_y   = res_r.box_max_y;
  assign out_ch.pen_x       = res_r.pen_x;
  assign out_ch.pen_y       = res_r.pen_y;

endmodule

// ===== rtl/dmce_checker.sv =====
// Port-level assertions for the draw macro command executor, bound to the top level.
module dmce_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [1:0]                           status,
  input logic signed [dmce_pkg::OUT_W-1:0]    seg_start_x,
  input logic signed [dmce_pkg::OUT_W-1:0]    seg_start_y,
  input logic signed [dmce_pkg::OUT_W-1:0]    seg_end_x,
  input logic signed [dmce_pkg::OUT_W-1:0]    seg_end_y,
  input logic signed [dmce_pkg::OUT_W-1:0]    box_min_x,
  input logic signed [dmce_pkg::OUT_W-1:0]    box_min_y,
  input logic signed [dmce_pkg::OUT_W-1:0]    box_max_x,
  input logic signed [dmce_pkg::OUT_W-1:0]    box_max_y
);

  // A stalled result beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its status and segment end point.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(status) && $stable(seg_end_x) && $stable(seg_end_y))
    else $error("result payload changed while stalled");

  // Segment fields are zero whenever no line is reported.
  a_seg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != dmce_pkg::ST_LINE |->
      seg_start_x == 0 && seg_start_y == 0 && seg_end_x == 0 && seg_end_y == 0)
    else $error("segment fields set without a line");

  // A drawn segment lies inside the reported box.
  a_seg_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == dmce_pkg::ST_LINE |->
      box_min_x <= seg_start_x && box_min_x <= seg_end_x &&
      box_max_x >= seg_start_x && box_max_x >= seg_end_x &&
      box_min_y <= seg_start_y && box_min_y <= seg_end_y &&
      box_max_y >= seg_start_y && box_max_y >= seg_end_y)
    else $error("segment outside bounding box");

endmodule

bind draw_macro_command_executor dmce_checker u_dmce_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .seg_start_x (out_ch.seg_start_x),
  .seg_start_y (out_ch.seg_start_y),
  .seg_end_x   (out_ch.seg_end_x),
  .seg_end_y   (out_ch.seg_end_y),
  .box_min_x   (out_ch.box_min_x),
  .box_min_y   (out_ch.box_min_y),
  .box_max_x   (out_ch.box_max_x),
  .box_max_y   (out_ch.box_max_y)
);

// ===== bench/testbench.sv =====
// Self-checking testbench for the draw macro command executor: pen model, random traffic.
`timescale 1ns / 1ps

module testbench;

  typedef logic [dmce_pkg::PARAM_W-1:0]  param_t;
  typedef logic [dmce_pkg::SCALE_W-1:0]  scale_t;
  typedef logic [dmce_pkg::CANVAS_W-1:0] canvas_t;
  typedef logic [dmce_pkg::OUT_W-1:0]    field_t;

  logic clk = 1'b0;
  logic rst_n;

  dmce_in_if  cmd_if ();
  dmce_out_if rpt_if ();
  dmce_cfg_if cfg_if ();

  draw_macro_command_executor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_if),
    .out_ch (rpt_if),
    .cfg_ch (cfg_if)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pen state as the block should hold it.
  int                            pen_pos_x, pen_pos_y;
  int                            box_lo_x, box_lo_y, box_hi_x, box_hi_y;
  scale_t                        cur_scale;
  logic [dmce_pkg::COLOR_W-1:0]  cur_color;
  bit                            lift_pending, home_pending;

  // Reports still owed by the block, oldest first.
  dmce_pkg::result_t pending_reports[$];
  int      mismatches = 0;
  bit      no_idle = 1'b0;

  function automatic int imin(input int p, input int q);
    return (q < p) ? q : p;
  endfunction

  function automatic int imax(input int p, input int q);
    return (p < q) ? q : p;
  endfunction

  // Gap length for either side: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // Argument values: small distances most of the time, extremes and full-range noise too.
  function automatic param_t pick_param();
    int r;
    param_t corner [7];
    corner = '{16'h8000, 16'h8001, 16'hffff, 16'h0000, 16'h0001, 16'h7ffe, 16'h7fff};
    r = $urandom_range(0, 99);
    if (r < 50) return param_t'($urandom_range(0, 40) - 20);
    if (r < 70) return param_t'($urandom_range(0, 600) - 300);
    if (r < 85) return corner[$urandom_range(0, 6)];
    return param_t'($urandom);
  endfunction

  // Apply one command to the pen state and return the report it must produce.
  function automatic dmce_pkg::result_t advance_pen(input dmce_pkg::cmd_e c,
      input logic signed [dmce_pkg::PARAM_W-1:0] a,
      input logic signed [dmce_pkg::PARAM_W-1:0] b);
    dmce_pkg::result_t rpt;
    int      move_len, tx, ty, quot;
    bit      moving;
    rpt = '0;
    rpt.status = dmce_pkg::ST_NONE;
    move_len = int'(cur_scale) * int'(a);
    tx = pen_pos_x;
    ty = pen_pos_y;
    moving = 1'b1;
    case (c)
      dmce_pkg::CMD_U: ty = pen_pos_y - move_len;
      dmce_pkg::CMD_D: ty = pen_pos_y + move_len;
      dmce_pkg::CMD_L: tx = pen_pos_x - move_len;
      dmce_pkg::CMD_R: tx = pen_pos_x + move_len;
      dmce_pkg::CMD_E: begin tx = pen_pos_x + move_len; ty = pen_pos_y - move_len; end
      dmce_pkg::CMD_F: begin tx = pen_pos_x + move_len; ty = pen_pos_y + move_len; end
      dmce_pkg::CMD_G: begin tx = pen_pos_x - move_len; ty = pen_pos_y + move_len; end
      dmce_pkg::CMD_H: begin tx = pen_pos_x - move_len; ty = pen_pos_y - move_len; end
      dmce_pkg::CMD_M: begin tx = move_len; ty = int'(cur_scale) * int'(b); end
      default: moving = 1'b0;
    endcase

    if (moving) begin
      // A lifted pen moves without drawing; the lift lasts for one move only.
      if (!lift_pending) begin
        rpt.status = dmce_pkg::ST_LINE;
        rpt.seg_start_x = pen_pos_x;
        rpt.seg_start_y = pen_pos_y;
        rpt.seg_end_x = tx;
        rpt.seg_end_y = ty;
        box_lo_x = imin(box_lo_x, imin(pen_pos_x, tx));
        box_lo_y = imin(box_lo_y, imin(pen_pos_y, ty));
        box_hi_x = imax(box_hi_x, imax(pen_pos_x, tx));
        box_hi_y = imax(box_hi_y, imax(pen_pos_y, ty));
      end else begin
        lift_pending = 1'b0;
      end
      // A pending return keeps the pen where the move started.
      if (!home_pending) begin
        pen_pos_x = tx;
        pen_pos_y = ty;
      end else begin
        home_pending = 1'b0;
      end
    end else begin
      case (c)
        dmce_pkg::CMD_B: lift_pending = 1'b1;
        dmce_pkg::CMD_N: home_pending = 1'b1;
        dmce_pkg::CMD_C: cur_color = a[dmce_pkg::COLOR_W-1:0];
        dmce_pkg::CMD_S: begin
          quot = int'(a) / 4;
          cur_scale = (quot < 0) ? '0 :
                      ((quot > 255) ? dmce_pkg::SCALE_MAX : scale_t'(quot));
        end
        dmce_pkg::CMD_A, dmce_pkg::CMD_T: ;
        default: rpt.status = dmce_pkg::ST_UNKNOWN;
      endcase
    end

    rpt.line_color = cur_color;
    rpt.box_min_x = box_lo_x;
    rpt.box_min_y = box_lo_y;
    rpt.box_max_x = box_hi_x;
    rpt.box_max_y = box_hi_y;
    rpt.pen_x = pen_pos_x;
    rpt.pen_y = pen_pos_y;
    return rpt;
  endfunction

  // Send one command beat. Entered and left at a falling edge; valid stays high on return.
  task automatic send_cmd(input dmce_pkg::cmd_e c, input param_t a, input param_t b);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid = 1'b1;
    cmd_if.cmd = c;
    cmd_if.param_a = a;
    cmd_if.param_b = b;
    do @(posedge clk); while (!cmd_if.ready);
    pending_reports.push_back(advance_pen(c, a, b));
    @(negedge clk);
  endtask

  // Stop sending and wait until every owed report has come back.
  task automatic wait_drain();
    cmd_if.valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one canvas register; only called while the block is idle.
  task automatic write_canvas(input dmce_pkg::cfg_idx_e idx, input canvas_t v);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = v;
    do @(posedge clk); while (!cfg_if.ready);
    // A canvas write re-homes that axis of the pen and the box.
    if (idx == dmce_pkg::CFG_CANVAS_WIDTH) begin
      pen_pos_x = int'(v >> 1);
      box_lo_x = pen_pos_x;
      box_hi_x = pen_pos_x;
    end else begin
      pen_pos_y = int'(v >> 1);
      box_lo_y = pen_pos_y;
      box_hi_y = pen_pos_y;
    end
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // One random command, weighted toward moves so the box and pen keep changing.
  task automatic send_random_cmd();
    int   r;
    dmce_pkg::cmd_e c;
    param_t a;
    r = $urandom_range(0, 99);
    if (r < 55) c = dmce_pkg::cmd_e'($urandom_range(0, 7));
    else if (r < 64) c = dmce_pkg::CMD_M;
    else if (r < 72) c = dmce_pkg::CMD_B;
    else if (r < 79) c = dmce_pkg::CMD_N;
    else if (r < 85) c = dmce_pkg::CMD_C;
    else if (r < 92) c = dmce_pkg::CMD_S;
    else if (r < 97) c = ($urandom_range(0, 1) != 0) ? dmce_pkg::CMD_A : dmce_pkg::CMD_T;
    else c = dmce_pkg::CMD_UNK;
    a = pick_param();
    // Keep the scale mostly small so moves stay readable; large scales still happen.
    if (c == dmce_pkg::CMD_S && $urandom_range(0, 3) != 0) a = param_t'($urandom_range(0, 40));
    send_cmd(c, a, pick_param());
  endtask

  // Extremes of the arguments, every command, and the flag and clamp corner cases.
  task automatic test_directed();
    send_cmd(dmce_pkg::CMD_R, 16'sd10, 16'sd0);
    send_cmd(dmce_pkg::CMD_U, 16'sh7fff, 16'sh7fff);
    send_cmd(dmce_pkg::CMD_D, 16'sh8000, 16'sh8000);
    send_cmd(dmce_pkg::CMD_C, 16'shffff, 16'sd0);
    send_cmd(dmce_pkg::CMD_C, 16'sd6, 16'sd0);
    send_cmd(dmce_pkg::CMD_S, -16'sd5, 16'sd0);
    send_cmd(dmce_pkg::CMD_L, 16'sd100, 16'sd0);
    send_cmd(dmce_pkg::CMD_S, 16'sh7fff, 16'sd0);
    send_cmd(dmce_pkg::CMD_M, 16'sh7fff, 16'sh8000);
    send_cmd(dmce_pkg::CMD_S, 16'sd4, 16'sd0);
    // Lift, then a non-move that must leave the lift pending.
    send_cmd(dmce_pkg::CMD_B, 16'sh7fff, 16'sh8000);
    send_cmd(dmce_pkg::CMD_A, 16'sd5, 16'sd0);
    send_cmd(dmce_pkg::CMD_G, 16'sd7, 16'sd0);
    // Return-home: the move draws but the pen stays.
    send_cmd(dmce_pkg::CMD_N, 16'sh8000, 16'sh7fff);
    send_cmd(dmce_pkg::CMD_T, 16'sd1, 16'sd0);
    send_cmd(dmce_pkg::CMD_F, -16'sd3, 16'sd0);
    // Both flags on one move.
    send_cmd(dmce_pkg::CMD_B, 16'sd0, 16'sd0);
    send_cmd(dmce_pkg::CMD_N, 16'sd0, 16'sd0);
    send_cmd(dmce_pkg::CMD_H, 16'sd9, 16'sd0);
    send_cmd(dmce_pkg::CMD_UNK, 16'sh8000, 16'sh7fff);
    send_cmd(dmce_pkg::CMD_E, 16'sh7fff, 16'sd0);
    send_cmd(dmce_pkg::CMD_S, 16'sd16, 16'sd0);
    send_cmd(dmce_pkg::CMD_M, 16'sd0, 16'sd0);
    send_cmd(dmce_pkg::CMD_D, 16'sd1, 16'sd0);
    send_cmd(dmce_pkg::CMD_L, 16'sh8000, 16'sd0);
  endtask

  // Long diagonal runs at full scale until both coordinates wrap around.
  task automatic test_coordinate_wrap();
    send_cmd(dmce_pkg::CMD_S, 16'sd1020, 16'sd0);
    repeat (270) send_cmd(dmce_pkg::CMD_E, 16'sh7fff, 16'sd0);
    repeat (10) send_cmd(dmce_pkg::CMD_F, 16'sh8000, 16'sd0);
  endtask

  // Several canvas settings, extremes included, each followed by random traffic.
  task automatic test_canvas_settings();
    canvas_t wd [5];
    canvas_t ht [5];
    wd = '{16'd1, 16'd65535, 16'd0, 16'd0, 16'd320};
    ht = '{16'd65535, 16'd1, 16'd0, 16'd0, 16'd200};
    for (int k = 0; k < 5; k++) begin
      if (wd[k] == 0) wd[k] = canvas_t'($urandom_range(1, 65535));
      if (ht[k] == 0) ht[k] = canvas_t'($urandom_range(1, 65535));
      wait_drain();
      // One phase moves only the x axis home, leaving y and the one-shot flags alone.
      write_canvas(dmce_pkg::CFG_CANVAS_WIDTH, wd[k]);
      if (k != 2) write_canvas(dmce_pkg::CFG_CANVAS_HEIGHT, ht[k]);
      repeat (48) send_random_cmd();
    end
  endtask

  // Free-running random commands with bursts of no idling and one full pause.
  task automatic test_random_commands(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 4) == 0);
      if (n == count / 2) wait_drain();
      send_random_cmd();
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stalls, with stretches of steady ready.
  initial begin
    int stall_left;
    stall_left = 0;
    rpt_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (no_idle) begin
        rpt_if.ready = 1'b1;
      end else if (stall_left > 0) begin
        rpt_if.ready = 1'b0;
        stall_left--;
      end else begin
        rpt_if.ready = 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input field_t want, input field_t got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each report beat with the oldest one owed.
  always @(posedge clk) begin
    dmce_pkg::result_t want;
    if (rst_n && rpt_if.valid && rpt_if.ready) begin
      if (pending_reports.size() == 0) begin
        $error("report beat with nothing outstanding");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", field_t'(want.status), field_t'(rpt_if.status));
        check_field("seg_start_x", want.seg_start_x, rpt_if.seg_start_x);
        check_field("seg_start_y", want.seg_start_y, rpt_if.seg_start_y);
        check_field("seg_end_x", want.seg_end_x, rpt_if.seg_end_x);
        check_field("seg_end_y", want.seg_end_y, rpt_if.seg_end_y);
        check_field("line_color", field_t'(want.line_color), field_t'(rpt_if.line_color));
        check_field("box_min_x", want.box_min_x, rpt_if.box_min_x);
        check_field("box_min_y", want.box_min_y, rpt_if.box_min_y);
        check_field("box_max_x", want.box_max_x, rpt_if.box_max_x);
        check_field("box_max_y", want.box_max_y, rpt_if.box_max_y);
        check_field("pen_x", want.pen_x, rpt_if.pen_x);
        check_field("pen_y", want.pen_y, rpt_if.pen_y);
      end
    end
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Reset, then the tests in turn.
  initial begin
    rst_n = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.cmd = dmce_pkg::CMD_A;
    cmd_if.param_a = '0;
    cmd_if.param_b = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = dmce_pkg::CFG_CANVAS_WIDTH;
    cfg_if.data = '0;

    pen_pos_x = int'(dmce_pkg::CANVAS_W_RST >> 1);
    pen_pos_y = int'(dmce_pkg::CANVAS_H_RST >> 1);
    box_lo_x = pen_pos_x;
    box_hi_x = pen_pos_x;
    box_lo_y = pen_pos_y;
    box_hi_y = pen_pos_y;
    cur_scale = dmce_pkg::SCALE_RST;
    cur_color = dmce_pkg::COLOR_RST;
    lift_pending = 1'b0;
    home_pending = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_coordinate_wrap();
    test_canvas_settings();
    test_random_commands(300);
    wait_drain();
    repeat (8) @(negedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== draw_macro_command_executor.f =====
rtl/dmce_pkg.sv
rtl/dmce_if.sv
rtl/dmce_step.sv
rtl/draw_macro_command_executor.sv
rtl/dmce_checker.sv
bench/testbench.sv
